@@ rtl/core/cbnp_pkg.sv @@
// ---------------------------------------------------------------------------
// cbnp_pkg: shared types and constants for the custom base number parser
// Command codes, parse phases and the control word that is passed from the
// lookup stage to the accumulate stage.
// ---------------------------------------------------------------------------
`default_nettype none

package cbnp_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_SYMBOL = 2'd1,
    CMD_CHAR   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Parse phase, one-hot.
  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  localparam int DIGIT_W = 7;

  localparam logic [7:0] CH_TAB_LO = 8'h09;
  localparam logic [7:0] CH_TAB_HI = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  // Work handed to the accumulate stage. For CMD_CHAR the digit arrives
  // from the digit memory in the same cycle.
  typedef struct packed {
    logic                 valid;
    cmd_t                 op;
    logic [DIGIT_W-1:0]   base;
    logic                 neg;
    logic                 bad;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/custom_base_number_parser.sv @@
// ---------------------------------------------------------------------------
// custom_base_number_parser: integer parser over a loadable digit alphabet
// Loads an alphabet one symbol per item, then parses a character stream
// into a signed integer in that base.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, command, char_code) takes one item
// per cycle while in_stall is low. Command clear empties the alphabet and
// the parse, symbol appends an alphabet symbol, char feeds a string
// character, and end closes a string. Only end produces a result on the
// output channel (out_valid, out_stall, value, status): the digit memory is
// read and the control state updated, then the output register is loaded.
// Throughput is one item per cycle while in_stall is low, set by the digit
// memory (single-port), read for every item and written on a good symbol.
// When the receiver stalls, the finished result sits in the output register
// and the input keeps taking items; in_stall rises only once a second end of
// string has reached the accumulate stage behind the stalled result.
// Reset empties the alphabet and the parse state at once; the digit memory
// itself is not cleared, since a symbol's presence bit gates every read.
// ---------------------------------------------------------------------------
`default_nettype none

module custom_base_number_parser
  import cbnp_pkg::*;
#(
  parameter int SYMBOL_CODES = 128,
  parameter int VALUE_WIDTH  = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [7:0]                 char_code,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [VALUE_WIDTH-1:0]   value,
  output logic                            status
);

  localparam int IDX_W = $clog2(SYMBOL_CODES);

  logic [DIGIT_W-1:0]      digit_mem [SYMBOL_CODES];
  logic [DIGIT_W-1:0]      digit_rd;
  logic [SYMBOL_CODES-1:0] present;
  logic [DIGIT_W-1:0]      alpha_len;
  logic                    alpha_bad;
  phase_t                  phase;
  logic                    negative;
  stage_t                  stage;
  stage_t                  stage_next;
  logic                    hold;
  logic                    accept;
  cmd_t                    cmd;
  logic [IDX_W-1:0]        idx;
  logic                    sym_hit;
  logic                    is_space;
  logic                    sym_ok;
  logic                    lead_skip;
  logic                    lead_minus;
  logic                    parsing;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign cmd      = cmd_t'(command);
  assign idx      = char_code[IDX_W-1:0];

  // Symbol lookup and character classes.
  assign sym_hit  = (int'(char_code) < SYMBOL_CODES) && present[idx];
  assign is_space = (char_code >= CH_TAB_LO && char_code <= CH_TAB_HI) ||
                    (char_code == CH_SPACE);
  assign sym_ok   = !(char_code == CH_PLUS || char_code == CH_MINUS ||
                      char_code <= CH_SPACE || char_code >= CH_DEL || sym_hit);
  assign lead_skip  = (phase == PH_LEAD) && (is_space || char_code == CH_PLUS);
  assign lead_minus = (phase == PH_LEAD) && (char_code == CH_MINUS);
  assign parsing    = (phase == PH_LEAD) || (phase == PH_DIGITS);

  // Digit memory: written on a good symbol, read for every transfer.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_SYMBOL && sym_ok) begin
      digit_mem[idx] <= alpha_len;
    end
    if (accept) begin
      digit_rd <= digit_mem[idx];
    end
  end

  // Alphabet and parse control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      alpha_len <= '0;
      alpha_bad <= 1'b0;
      phase     <= PH_LEAD;
      negative  <= 1'b0;
    end else if (accept) begin
      case (cmd)
        CMD_CLEAR: begin
          present   <= '0;
          alpha_len <= '0;
          alpha_bad <= 1'b0;
          phase     <= PH_LEAD;
          negative  <= 1'b0;
        end
        CMD_SYMBOL: begin
          if (sym_ok) begin
            present[idx] <= 1'b1;
            alpha_len    <= alpha_len + 1'b1;
          end else begin
            alpha_bad <= 1'b1;
          end
        end
        CMD_CHAR: begin
          if (lead_minus) begin
            negative <= ~negative;
          end else if (!lead_skip && parsing) begin
            phase <= sym_hit ? PH_DIGITS : PH_DONE;
          end
        end
        CMD_END: begin
          phase    <= PH_LEAD;
          negative <= 1'b0;
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  // Work for the accumulate stage; non-digit characters need none.
  always_comb begin
    stage_next       = '0;
    stage_next.op    = cmd;
    stage_next.base  = alpha_len;
    stage_next.neg   = negative;
    stage_next.bad   = alpha_bad || (alpha_len < DIGIT_W'(2));
    case (cmd)
      CMD_CHAR: stage_next.valid = accept && !lead_skip && !lead_minus &&
                                   parsing && sym_hit;
      default:  stage_next.valid = accept;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else if (!hold) begin
      stage <= stage_next;
    end
  end

  cbnp_accum #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .digit     (digit_rd),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

endmodule

`default_nettype wire

@@ rtl/core/cbnp_accum.sv @@
// ---------------------------------------------------------------------------
// cbnp_accum: accumulate stage and output register
// Folds each digit into the accumulator as value*base+digit, and on end of
// string loads the signed result into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cbnp_accum
  import cbnp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stage_t                        stage,
  input  wire logic [DIGIT_W-1:0]            digit,
  output logic                               hold,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      value,
  output logic                               status
);

  localparam int PROD_W = VALUE_WIDTH + DIGIT_W;

  logic [VALUE_WIDTH-1:0] acc;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_WIDTH-1:0] acc_step;
  logic [VALUE_WIDTH-1:0] result;
  logic                   is_end;

  // One multiply-add per digit, wrapping to the value width.
  assign prod     = PROD_W'(acc) * PROD_W'(stage.base);
  assign acc_step = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit);

  // Signed result, forced to zero for an unusable alphabet.
  always_comb begin
    if (stage.bad) begin
      result = '0;
    end else if (stage.neg) begin
      result = '0 - acc;
    end else begin
      result = acc;
    end
  end

  // The stage waits only when an end of string meets a full, stalled output.
  assign is_end = stage.valid && (stage.op == CMD_END);
  assign hold   = is_end && out_valid && out_stall;

  // Accumulator update in command order.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (stage.valid && !hold) begin
      case (stage.op)
        CMD_CHAR:  acc <= acc_step;
        CMD_CLEAR: acc <= '0;
        CMD_END:   acc <= '0;
        default:   acc <= acc;
      endcase
    end
  end

  // Output register: a transfer frees it, an end of string fills it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_end && !hold) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_end && !hold) begin
      value  <= result;
      status <= stage.bad;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/custom_base_number_parser_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// custom_base_number_parser_tb: self-checking bench for the base parser
// Loads digit alphabets and feeds character strings over the input channel.
// An in-bench model predicts each end-of-string result, and a monitor checks
// every output transfer against the oldest prediction. Directed tests cover
// invalid alphabets, sign handling, terminators and mid-parse appends. An
// output hold-off test fills the pipeline, and a random phase runs mostly
// well-formed alphabet and string sequences with some raw noise mixed in.
// ---------------------------------------------------------------------------

module custom_base_number_parser_tb;
  import cbnp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_SYMBOLS  = 92;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } parse_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_CLEAR;
  logic [7:0]         char_code = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value;
  logic               status;

  // Model state of the alphabet table and the running parse.
  logic               alpha_present [128];
  logic [6:0]         alpha_digit [128];
  logic [6:0]         alpha_len = '0;
  logic               alpha_bad = 1'b0;
  phase_t             parse_phase = PH_LEAD;
  logic               parse_neg = 1'b0;
  logic [31:0]        parse_acc = '0;

  parse_result_t      expected_numbers [$];
  parse_result_t      oldest_number;

  bit                 idle_enable = 1'b1;
  bit                 stall_enable = 1'b1;
  int                 hold_req = 0;
  int                 hold_ack = 0;
  int                 stall_left = 0;
  int                 cycle_count = 0;
  int                 useful_items = 0;
  int                 results_checked = 0;
  int                 invalid_expected = 0;
  int                 input_stall_cycles = 0;
  int                 mismatch_count = 0;

  custom_base_number_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached.", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sender idle length: mostly none or short, now and then long.
  function automatic int sender_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stall: random stretches, plus a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      out_stall <= 1'b1;
      stall_left <= HOLD_CYCLES - 1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic restart_parse();
    parse_phase = PH_LEAD;
    parse_neg = 1'b0;
    parse_acc = '0;
  endtask

  // Apply one accepted item to the model and queue any result it produces.
  task automatic predict_parse(input cmd_t cmd, input logic [7:0] ch);
    parse_result_t r;
    case (cmd)
      CMD_CLEAR: begin
        foreach (alpha_present[i]) alpha_present[i] = 1'b0;
        alpha_len = '0;
        alpha_bad = 1'b0;
        restart_parse();
      end
      CMD_SYMBOL: begin
        if (ch == CH_PLUS || ch == CH_MINUS || ch <= CH_SPACE || ch >= CH_DEL ||
            alpha_present[ch[6:0]]) begin
          alpha_bad = 1'b1;
        end else begin
          alpha_present[ch[6:0]] = 1'b1;
          alpha_digit[ch[6:0]] = alpha_len;
          alpha_len = alpha_len + 7'd1;
        end
      end
      CMD_CHAR: begin
        if (parse_phase == PH_LEAD &&
            ((ch >= CH_TAB_LO && ch <= CH_TAB_HI) || ch == CH_SPACE || ch == CH_PLUS)) begin
          // Leading whitespace and plus signs are skipped.
        end else if (parse_phase == PH_LEAD && ch == CH_MINUS) begin
          parse_neg = ~parse_neg;
        end else if (parse_phase != PH_DONE) begin
          if (ch[7] == 1'b0 && alpha_present[ch[6:0]]) begin
            parse_acc = parse_acc * {25'd0, alpha_len} + {25'd0, alpha_digit[ch[6:0]]};
            parse_phase = PH_DIGITS;
          end else begin
            parse_phase = PH_DONE;
          end
        end
      end
      default: begin
        r.status = alpha_bad || alpha_len < 7'd2;
        if (r.status) r.value = '0;
        else r.value = parse_neg ? 32'd0 - parse_acc : parse_acc;
        if (r.status) invalid_expected++;
        expected_numbers.push_back(r);
        restart_parse();
      end
    endcase
  endtask

  // Offer one item, wait for its transfer, then idle for a random gap.
  task automatic send_item(input cmd_t cmd, input logic [7:0] ch);
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(cmd == CMD_CHAR && parse_phase == PH_DONE)) useful_items++;
    predict_parse(cmd, ch);
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Compare every output transfer with the oldest expected result.
  always @(posedge clk) begin
    if (in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_numbers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result, value %0d status %0b", value, status);
      end else begin
        oldest_number = expected_numbers.pop_front();
        results_checked++;
        if (value !== oldest_number.value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d value expected %0d, got %0d",
                     results_checked, oldest_number.value, value);
        end
        if (status !== oldest_number.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d status expected %0b, got %0b",
                     results_checked, oldest_number.status, status);
        end
      end
    end
  end

  // Empty alphabet, a one-symbol alphabet and a rejected symbol.
  task automatic test_invalid_alphabets();
    send_item(CMD_END, 8'hff);
    send_item(CMD_CLEAR, 8'hff);
    send_item(CMD_SYMBOL, 8'h21);
    send_item(CMD_END, 8'h00);
    send_item(CMD_SYMBOL, CH_PLUS);
    send_item(CMD_SYMBOL, "1");
    send_item(CMD_END, 8'h00);
    wait_for_results();
  endtask

  // Leading whitespace and signs, then digits ended by a byte above the table.
  task automatic test_sign_and_terminator();
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_SYMBOL, "0");
    send_item(CMD_SYMBOL, "1");
    send_item(CMD_CHAR, CH_SPACE);
    send_item(CMD_CHAR, CH_TAB_LO);
    send_item(CMD_CHAR, CH_TAB_HI);
    send_item(CMD_CHAR, CH_MINUS);
    send_item(CMD_CHAR, CH_PLUS);
    send_item(CMD_CHAR, "1");
    send_item(CMD_CHAR, "0");
    send_item(CMD_CHAR, 8'h80);
    send_item(CMD_CHAR, "1");
    send_item(CMD_END, 8'hff);
    wait_for_results();
  endtask

  // A symbol appended mid-string changes the base for later digits; a repeat
  // of an existing symbol spoils the alphabet.
  task automatic test_mid_parse_append();
    send_item(CMD_CHAR, "1");
    send_item(CMD_SYMBOL, 8'h7e);
    send_item(CMD_CHAR, 8'h7e);
    send_item(CMD_END, 8'h00);
    send_item(CMD_SYMBOL, "0");
    send_item(CMD_END, 8'h00);
    wait_for_results();
  endtask

  // Hold the output off while back-to-back strings fill the pipeline.
  task automatic test_output_backpressure();
    idle_enable = 1'b0;
    stall_enable = 1'b0;
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_SYMBOL, "0");
    send_item(CMD_SYMBOL, "1");
    hold_req++;
    repeat (24) begin
      send_item(CMD_CHAR, "1");
      send_item(CMD_END, 8'h00);
    end
    wait_for_results();
    idle_enable = 1'b1;
    stall_enable = 1'b1;
  endtask

  // One random alphabet followed by a few strings, or a burst of raw noise.
  task automatic run_random_sequence();
    logic [7:0] pool [NUM_SYMBOLS];
    logic [7:0] tmp;
    logic [7:0] ch;
    int         c;
    int         idx;
    int         j;
    int         r;
    int         n;
    int         loaded;
    int         bad_at;
    int         k;
    idle_enable = $urandom_range(0, 3) != 0;
    stall_enable = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 10))
        send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      return;
    end

    // Shuffle every legal symbol and use a prefix as the alphabet.
    idx = 0;
    for (c = 'h21; c <= 'h7e; c++) begin
      if (c != CH_PLUS && c != CH_MINUS) begin
        pool[idx] = 8'(c);
        idx++;
      end
    end
    for (j = NUM_SYMBOLS - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = pool[j];
      pool[j] = pool[k];
      pool[k] = tmp;
    end
    r = $urandom_range(0, 99);
    if (r < 5) n = $urandom_range(0, 1);
    else if (r < 90) n = $urandom_range(2, 16);
    else if (r < 97) n = $urandom_range(17, 60);
    else n = $urandom_range(61, NUM_SYMBOLS);
    bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;

    send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
    for (j = 0; j <= n; j++) begin
      if (j == bad_at) begin
        case ($urandom_range(0, 4))
          0: ch = CH_PLUS;
          1: ch = CH_MINUS;
          2: ch = 8'($urandom_range(0, 32));
          3: ch = 8'($urandom_range(127, 255));
          default: ch = (j > 0) ? pool[$urandom_range(0, j - 1)] : CH_SPACE;
        endcase
        send_item(CMD_SYMBOL, ch);
      end
      if (j < n) send_item(CMD_SYMBOL, pool[j]);
    end
    loaded = n;

    repeat ($urandom_range(1, 6)) begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 3))
          0: ch = 8'($urandom_range(9, 13));
          1: ch = CH_SPACE;
          2: ch = CH_PLUS;
          default: ch = CH_MINUS;
        endcase
        send_item(CMD_CHAR, ch);
      end
      // Long digit runs can push the accumulator past 32 bits.
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      repeat (k) begin
        if (loaded < NUM_SYMBOLS && $urandom_range(0, 29) == 0) begin
          send_item(CMD_SYMBOL, pool[loaded]);
          loaded++;
        end
        if (loaded == 0) ch = 8'($urandom_range(0, 255));
        else ch = pool[$urandom_range(0, loaded - 1)];
        send_item(CMD_CHAR, ch);
      end
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 4)) send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
      send_item(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_streams();
    int first;
    first = useful_items;
    while (useful_items - first < RANDOM_ITEMS) run_random_sequence();
    idle_enable = 1'b1;
    stall_enable = 1'b1;
    wait_for_results();
  endtask

  initial begin
    foreach (alpha_present[i]) alpha_present[i] = 1'b0;
    foreach (alpha_digit[i]) alpha_digit[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_invalid_alphabets();
    test_sign_and_terminator();
    test_mid_parse_append();
    test_output_backpressure();
    test_random_streams();

    $display("Sent %0d items and checked %0d parsed numbers, %0d of them invalid-alphabet.",
             useful_items, results_checked, invalid_expected);
    $display("Input was held off for %0d cycles; %0d mismatches found.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && expected_numbers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cbnp_pkg.sv
rtl/core/cbnp_accum.sv
rtl/core/custom_base_number_parser.sv
tb/sv/custom_base_number_parser_tb.sv
